// ===== sv/ptig_pkg.sv =====
// Shared constants and types for the polygon tessellation index generator.
`timescale 1ns / 1ps

package ptig_pkg;

  // Default limits for the side count and the resolution.
  localparam int MAX_SIDES_DEF = 16;
  localparam int MAX_RES_DEF   = 64;

  // Fixed field widths.
  localparam int VW       = 16;  // vertex index width
  localparam int SIDES_W  = 5;   // sides_count register width
  localparam int RES_W    = 7;   // resolution_level register width
  localparam int CFG_DW   = 32;  // configuration data width
  localparam int CFG_AW   = 3;   // configuration byte address width
  localparam int IN_DW    = 8;   // input tdata width
  localparam int OUT_DW   = 3 * VW;

  // Register indexes, taken from paddr[2].
  localparam logic REG_SIDES = 1'b0;
  localparam logic REG_RES   = 1'b1;

  // Register reset values.
  localparam logic [SIDES_W-1:0] SIDES_RST = 5'd4;
  localparam logic [RES_W-1:0]   RES_RST   = 7'd8;

  // Side counts that select the grid modes.
  localparam int SIDES_TRI  = 3;
  localparam int SIDES_QUAD = 4;

  // Traversal reset values for the vertex pointers.
  localparam logic [VW-1:0] INNER_RST = 16'd0;
  localparam logic [VW-1:0] OUTER_RST = 16'd1;

  // Mesh building mode.
  typedef enum logic [1:0] {
    MODE_TRI,
    MODE_QUAD,
    MODE_RING
  } mode_t;

endpackage

// ===== sv/polygon_tessellation_index_gen_core.sv =====
// Top level of the polygon tessellation index generator: traversal counters and result register.
`timescale 1ns / 1ps

// Emits one triangle (three vertex indices, last flag on tlast) for each input word; bit 0 of
// in_tdata set restarts at the first triangle of the mesh. Each accepted word produces exactly
// one result word in the result register, and a new word is taken every cycle as long as the result
// register is empty or being drained, so the block sustains one triangle per clock. The
// traversal counters update in a single step from the current state, with one small multiplier
// for the quad-mode row offset. Writes to sides_count (address 0) or resolution_level
// (address 4) return the traversal to the first triangle.
module polygon_tessellation_index_gen_core
  import ptig_pkg::*;
#(
  parameter int MAX_SIDES      = MAX_SIDES_DEF,
  parameter int MAX_RESOLUTION = MAX_RES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input channel
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,    // [0] restart, [7:1] zero
  // Result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,   // [15:0] vertex_a, [31:16] vertex_b, [47:32] vertex_c
  output logic              out_tlast,   // last_triangle
  // Configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int SW  = $clog2(MAX_SIDES + 1);
  localparam int SCW = $clog2(MAX_SIDES);
  localparam int LW  = $clog2(MAX_RESOLUTION + 1);

  // Configuration registers
  logic [SIDES_W-1:0] sides_r;
  logic [RES_W-1:0]   res_r;
  logic               cfg_wr;

  // Traversal state
  logic [LW-1:0]  layer_r, layer_nxt;
  logic [LW-1:0]  pos_r, pos_nxt;
  logic [SCW-1:0] side_r, side_nxt;
  logic [VW-1:0]  inner_r, inner_nxt;
  logic [VW-1:0]  outer_r, outer_nxt;
  logic [VW-1:0]  inner_base_r, inner_base_nxt;
  logic [VW-1:0]  outer_base_r, outer_base_nxt;
  logic           half_r, half_nxt;

  // State seen by the current word, after an optional restart
  logic [LW-1:0]  cur_layer, cur_pos;
  logic [SCW-1:0] cur_side;
  logic [VW-1:0]  cur_inner, cur_outer, cur_inner_base, cur_outer_base;
  logic           cur_half;

  logic [SW-1:0]  n_eff;
  logic [LW-1:0]  res_eff;
  mode_t          mode;

  logic           in_acc;
  logic [VW-1:0]  va, vb, vc;
  logic           last;

  logic [LW-1:0]  layer_inc, pos_inc;
  logic [SW-1:0]  side_inc;
  logic [VW-1:0]  jv, iv, res1v, idx;
  logic [2*LW:0]  row_prod;
  logic           corner;

  // Result register
  logic              out_valid_r;
  logic [OUT_DW-1:0] out_data_r;
  logic              out_last_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign in_tready  = ~out_valid_r | out_tready;
  assign in_acc     = in_tvalid & in_tready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sides_r <= SIDES_RST;
      res_r   <= RES_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_SIDES: sides_r <= cfg_pwdata[SIDES_W-1:0];
        REG_RES:   res_r   <= cfg_pwdata[RES_W-1:0];
        default:   sides_r <= sides_r;
      endcase
    end
  end

  // Configuration reads
  always_comb begin
    case (cfg_paddr[2])
      REG_SIDES: cfg_prdata = CFG_DW'(sides_r);
      REG_RES:   cfg_prdata = CFG_DW'(res_r);
      default:   cfg_prdata = '0;
    endcase
  end

  // Effective side count and resolution, clamped to their legal ranges
  always_comb begin
    if (32'(sides_r) > MAX_SIDES) begin
      n_eff = SW'(MAX_SIDES);
    end else if (32'(sides_r) < SIDES_TRI) begin
      n_eff = SW'(SIDES_TRI);
    end else begin
      n_eff = SW'(sides_r);
    end
    if (32'(res_r) > MAX_RESOLUTION) begin
      res_eff = LW'(MAX_RESOLUTION);
    end else if (res_r == '0) begin
      res_eff = LW'(1);
    end else begin
      res_eff = LW'(res_r);
    end
    if (32'(n_eff) == SIDES_TRI) begin
      mode = MODE_TRI;
    end else if (32'(n_eff) == SIDES_QUAD) begin
      mode = MODE_QUAD;
    end else begin
      mode = MODE_RING;
    end
  end

  // A restart request makes the word start from the first triangle
  always_comb begin
    if (in_tdata[0]) begin
      cur_layer      = '0;
      cur_pos        = '0;
      cur_side       = '0;
      cur_inner      = INNER_RST;
      cur_outer      = OUTER_RST;
      cur_inner_base = INNER_RST;
      cur_outer_base = OUTER_RST;
      cur_half       = 1'b0;
    end else begin
      cur_layer      = layer_r;
      cur_pos        = pos_r;
      cur_side       = side_r;
      cur_inner      = inner_r;
      cur_outer      = outer_r;
      cur_inner_base = inner_base_r;
      cur_outer_base = outer_base_r;
      cur_half       = half_r;
    end
  end

  // Shared arithmetic for the three modes
  assign layer_inc = cur_layer + LW'(1);
  assign pos_inc   = cur_pos + LW'(1);
  assign side_inc  = SW'(cur_side) + SW'(1);
  assign jv        = VW'(cur_pos);
  assign iv        = VW'(cur_layer);
  assign res1v     = VW'(res_eff) + VW'(1);
  assign row_prod  = cur_layer * ({1'b0, res_eff} + (LW+1)'(1));
  assign idx       = VW'(row_prod) + jv;
  assign corner    = (SW'(cur_side) == n_eff - SW'(1)) && (cur_pos == cur_layer);

  // Triangle and next traversal state
  always_comb begin
    layer_nxt      = cur_layer;
    pos_nxt        = cur_pos;
    side_nxt       = cur_side;
    inner_nxt      = cur_inner;
    outer_nxt      = cur_outer;
    inner_base_nxt = cur_inner_base;
    outer_base_nxt = cur_outer_base;
    half_nxt       = cur_half;
    va   = '0;
    vb   = '0;
    vc   = '0;
    last = 1'b0;
    case (mode)
      MODE_TRI: begin
        if (cur_pos < cur_layer) begin
          if (!cur_half) begin
            va       = cur_outer_base + jv;
            vb       = cur_outer_base + jv + VW'(1);
            vc       = cur_inner_base + jv;
            half_nxt = 1'b1;
          end else begin
            va       = cur_outer_base + jv + VW'(1);
            vb       = cur_inner_base + jv + VW'(1);
            vc       = cur_inner_base + jv;
            half_nxt = 1'b0;
            pos_nxt  = pos_inc;
          end
        end else begin
          // Closing triangle of the row
          va             = cur_outer_base + iv;
          vb             = cur_outer_base + iv + VW'(1);
          vc             = cur_inner_base + iv;
          inner_base_nxt = cur_outer_base;
          outer_base_nxt = cur_outer_base + iv + VW'(2);
          layer_nxt      = layer_inc;
          pos_nxt        = '0;
          half_nxt       = 1'b0;
          last           = (layer_inc >= res_eff);
        end
      end
      MODE_QUAD: begin
        if (!cur_half) begin
          va       = idx;
          vb       = idx + res1v;
          vc       = idx + VW'(1);
          half_nxt = 1'b1;
        end else begin
          va       = idx + VW'(1);
          vb       = idx + res1v;
          vc       = idx + res1v + VW'(1);
          half_nxt = 1'b0;
          if (pos_inc >= res_eff) begin
            pos_nxt   = '0;
            layer_nxt = layer_inc;
            last      = (layer_inc >= res_eff);
          end else begin
            pos_nxt = pos_inc;
          end
        end
      end
      default: begin
        // Ring mode: the corner of the last side closes the ring
        va = cur_inner;
        vb = cur_outer;
        if (!cur_half) begin
          vc        = corner ? cur_outer_base : cur_outer + VW'(1);
          outer_nxt = cur_outer + VW'(1);
          if (cur_pos >= cur_layer) begin
            pos_nxt = '0;
            if (side_inc >= n_eff) begin
              side_nxt       = '0;
              layer_nxt      = layer_inc;
              inner_base_nxt = cur_outer_base;
              outer_base_nxt = cur_outer + VW'(1);
              inner_nxt      = cur_outer_base;
              last           = (layer_inc >= res_eff);
            end else begin
              side_nxt = SCW'(side_inc);
            end
          end else begin
            pos_nxt  = pos_inc;
            half_nxt = 1'b1;
          end
        end else begin
          vc        = corner ? cur_inner_base : cur_inner + VW'(1);
          inner_nxt = vc;
          half_nxt  = 1'b0;
        end
      end
    endcase
  end

  // Traversal state update; the last triangle and any register write wrap to the start
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr || (in_acc && last)) begin
      layer_r      <= '0;
      pos_r        <= '0;
      side_r       <= '0;
      inner_r      <= INNER_RST;
      outer_r      <= OUTER_RST;
      inner_base_r <= INNER_RST;
      outer_base_r <= OUTER_RST;
      half_r       <= 1'b0;
    end else if (in_acc) begin
      layer_r      <= layer_nxt;
      pos_r        <= pos_nxt;
      side_r       <= side_nxt;
      inner_r      <= inner_nxt;
      outer_r      <= outer_nxt;
      inner_base_r <= inner_base_nxt;
      outer_base_r <= outer_base_nxt;
      half_r       <= half_nxt;
    end
  end

  // Result register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= {vc, vb, va};
      out_last_r <= last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  // The last triangle of the mesh leaves the traversal at its start.
  a_wrap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && last && !cfg_wr) |=> (layer_r == '0 && pos_r == '0 && side_r == '0 &&
                                     !half_r && outer_base_r == OUTER_RST))
    else $error("traversal did not wrap after the last triangle");

  // A register write restarts the traversal.
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (layer_r == '0 && pos_r == '0 && !half_r && inner_r == INNER_RST &&
                outer_r == OUTER_RST))
    else $error("register write did not restart the traversal");

  // The ring side counter stays below the effective side count.
  a_side_range: assert property (@(posedge clk) disable iff (!rst_n)
    SW'(side_r) < n_eff)
    else $error("side counter out of range");

  // The layer counter stays below the effective resolution.
  a_layer_range: assert property (@(posedge clk) disable iff (!rst_n)
    layer_r < res_eff)
    else $error("layer counter out of range");

  // A word is taken into the result register only when it is free or draining.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !in_acc)
    else $error("result register overwritten while stalled");
`endif

endmodule

// ===== dv/polygon_tessellation_index_gen_core_tb.sv =====
// Self-checking testbench for the polygon tessellation index generator core.
`timescale 1ns / 1ps

module polygon_tessellation_index_gen_core_tb;
  import ptig_pkg::*;

  localparam int RANDOM_WORDS = 700;
  localparam int PRINT_CAP    = 40;

  // One emitted triangle as the result channel carries it.
  typedef struct packed {
    logic [VW-1:0] va;
    logic [VW-1:0] vb;
    logic [VW-1:0] vc;
    logic          last;
  } tri_t;

  // Receiver stall patterns.
  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_LONG,
    RX_SPARSE
  } rx_mode_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata    = '0;   // [0] restart, [7:1] zero
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [OUT_DW-1:0] out_tdata;          // [15:0] vertex_a, [31:16] vertex_b, [47:32] vertex_c
  logic              out_tlast;          // last_triangle
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  polygon_tessellation_index_gen_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  // Mirror of the configuration registers.
  logic [SIDES_W-1:0] sides_cfg = SIDES_RST;
  logic [RES_W-1:0]   res_cfg   = RES_RST;

  // Mirror of the traversal state. The side counter is one bit wider than the block's so
  // that it can reach the side count before it wraps.
  logic [6:0]    walk_layer;
  logic [6:0]    walk_pos;
  logic [4:0]    walk_side;
  logic [VW-1:0] inner_v;
  logic [VW-1:0] outer_v;
  logic [VW-1:0] inner_base;
  logic [VW-1:0] outer_base;
  logic          walk_half;

  tri_t pending_tris[$];
  int   n_errors   = 0;
  int   burst_left = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    n_errors++;
    if (n_errors <= PRINT_CAP)
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  function automatic void restart_walk();
    walk_layer = '0;
    walk_pos   = '0;
    walk_side  = '0;
    inner_v    = INNER_RST;
    outer_v    = OUTER_RST;
    inner_base = INNER_RST;
    outer_base = OUTER_RST;
    walk_half  = 1'b0;
  endfunction

  // Side count and resolution after clamping to the supported range.
  function automatic int eff_sides();
    if (sides_cfg < SIDES_TRI) return SIDES_TRI;
    if (sides_cfg > MAX_SIDES_DEF) return MAX_SIDES_DEF;
    return int'(sides_cfg);
  endfunction

  function automatic int eff_res();
    if (res_cfg < 1) return 1;
    if (res_cfg > MAX_RES_DEF) return MAX_RES_DEF;
    return int'(res_cfg);
  endfunction

  function automatic mode_t mesh_mode();
    if (eff_sides() == SIDES_TRI) return MODE_TRI;
    if (eff_sides() == SIDES_QUAD) return MODE_QUAD;
    return MODE_RING;
  endfunction

  // Number of triangles in one full mesh under the current settings.
  function automatic int mesh_size();
    case (mesh_mode())
      MODE_TRI:  return eff_res() * eff_res();
      MODE_QUAD: return 2 * eff_res() * eff_res();
      default:   return eff_sides() * eff_res() * eff_res();
    endcase
  endfunction

  // Computes the triangle for one input word and steps the traversal state.
  function automatic tri_t advance_mesh(input logic rs);
    tri_t          t;
    int            n;
    int            res;
    int            i;
    int            j;
    int            idx;
    int            lyr;
    logic [VW-1:0] nxt;
    logic          end_of_side;
    n   = eff_sides();
    res = eff_res();
    t   = '0;
    if (rs) restart_walk();
    i = int'(walk_layer);
    j = int'(walk_pos);
    case (mesh_mode())
      MODE_TRI: begin
        if (j < i) begin
          if (!walk_half) begin
            t.va      = VW'(outer_base + j);
            t.vb      = VW'(outer_base + j + 1);
            t.vc      = VW'(inner_base + j);
            walk_half = 1'b1;
          end else begin
            t.va      = VW'(outer_base + j + 1);
            t.vb      = VW'(inner_base + j + 1);
            t.vc      = VW'(inner_base + j);
            walk_half = 1'b0;
            walk_pos  = 7'(j + 1);
          end
        end else begin
          // Closing triangle of the row.
          t.va       = VW'(outer_base + i);
          t.vb       = VW'(outer_base + i + 1);
          t.vc       = VW'(inner_base + i);
          inner_base = outer_base;
          outer_base = VW'(outer_base + i + 2);
          walk_layer = 7'(i + 1);
          walk_pos   = '0;
          walk_half  = 1'b0;
          if (i + 1 >= res) begin
            restart_walk();
            t.last = 1'b1;
          end
        end
      end
      MODE_QUAD: begin
        idx = i * (res + 1) + j;
        if (!walk_half) begin
          t.va      = VW'(idx);
          t.vb      = VW'(idx + res + 1);
          t.vc      = VW'(idx + 1);
          walk_half = 1'b1;
        end else begin
          t.va      = VW'(idx + 1);
          t.vb      = VW'(idx + res + 1);
          t.vc      = VW'(idx + res + 2);
          walk_half = 1'b0;
          j++;
          if (j >= res) begin
            j = 0;
            i++;
          end
          walk_pos   = 7'(j);
          walk_layer = 7'(i);
          if (i >= res) begin
            restart_walk();
            t.last = 1'b1;
          end
        end
      end
      default: begin
        // Ring mode: the last vertex of the last side closes back to the ring start.
        lyr         = i + 1;
        end_of_side = (walk_side == n - 1) && (j == lyr - 1);
        if (!walk_half) begin
          nxt  = end_of_side ? outer_base : VW'(outer_v + 1);
          t.va = inner_v;
          t.vb = outer_v;
          t.vc = nxt;
          outer_v++;
          if (j + 1 >= lyr) begin
            walk_pos = '0;
            walk_side++;
            if (walk_side >= n) begin
              walk_side  = '0;
              walk_layer++;
              inner_base = outer_base;
              outer_base = outer_v;
              inner_v    = inner_base;
              if (walk_layer >= res) begin
                restart_walk();
                t.last = 1'b1;
              end
            end
          end else begin
            walk_pos  = 7'(j + 1);
            walk_half = 1'b1;
          end
        end else begin
          nxt       = end_of_side ? inner_base : VW'(inner_v + 1);
          t.va      = inner_v;
          t.vb      = outer_v;
          t.vc      = nxt;
          inner_v   = nxt;
          walk_half = 1'b0;
        end
      end
    endcase
    return t;
  endfunction

  // Receiver: ready follows a stall pattern that is picked anew at random after each run of random length.
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 200);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_LONG:   out_tready <= ($urandom_range(0, 15) == 0) ? ~out_tready : out_tready;
      default:   out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Compare each accepted result word with the oldest expected triangle.
  always @(posedge clk) begin
    tri_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_tris.size() == 0) begin
        report_mismatch("triangle with no expectation", out_tdata[VW-1:0], 0);
      end else begin
        want = pending_tris.pop_front();
        if (out_tdata[VW-1:0] !== want.va)
          report_mismatch("vertex_a", out_tdata[VW-1:0], want.va);
        if (out_tdata[2*VW-1:VW] !== want.vb)
          report_mismatch("vertex_b", out_tdata[2*VW-1:VW], want.vb);
        if (out_tdata[3*VW-1:2*VW] !== want.vc)
          report_mismatch("vertex_c", out_tdata[3*VW-1:2*VW], want.vc);
        if (out_tlast !== want.last)
          report_mismatch("last_triangle", out_tlast, want.last);
      end
    end
  end

  // Sends one word, records its expected triangle, then either keeps the burst going or
  // drops valid for a random gap.
  task automatic send_word(input logic rs);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DW-1){1'b0}}, rs};
    do @(posedge clk); while (!in_tready);
    pending_tris = {pending_tris, advance_mesh(rs)};
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 10);
    end
  endtask

  // Holds the input until every expected triangle has come out.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_tris.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes one register while the block is idle, then reads it back.
  task automatic write_reg(input logic idx, input int value);
    logic [CFG_DW-1:0] word;
    logic [CFG_DW-1:0] kept;
    drain_results();
    word = $urandom();
    if (idx == REG_SIDES) word[SIDES_W-1:0] = value[SIDES_W-1:0];
    else word[RES_W-1:0] = value[RES_W-1:0];
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == REG_SIDES) begin
      sides_cfg = word[SIDES_W-1:0];
      kept      = CFG_DW'(sides_cfg);
    end else begin
      res_cfg = word[RES_W-1:0];
      kept    = CFG_DW'(res_cfg);
    end
    restart_walk();
    // Read back with a fresh setup phase.
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== kept) report_mismatch("register read back", cfg_prdata, kept);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_mesh(input int sides, input int res);
    write_reg(REG_SIDES, sides);
    write_reg(REG_RES, res);
  endtask

  // The default quad grid straight out of reset.
  task automatic test_reset_state();
    repeat (3) send_word(1'b0);
  endtask

  // Smallest meshes of each mode, so that the wrap after the last triangle shows.
  task automatic test_grid_modes();
    set_mesh(SIDES_TRI, 1);
    repeat (2) send_word(1'b0);
    set_mesh(SIDES_QUAD, 1);
    repeat (3) send_word(1'b0);
    set_mesh(5, 1);
    repeat (5) send_word(1'b0);
  endtask

  // Settings outside the supported range act as the nearest limit.
  task automatic test_clamped_settings();
    set_mesh(0, 0);
    repeat (2) send_word(1'b0);
    set_mesh(31, 127);
    repeat (3) send_word(1'b0);
    send_word(1'b1);
    send_word(1'b0);
    set_mesh(2, 65);
    repeat (2) send_word(1'b0);
  endtask

  // Restart in the middle of a mesh and twice in a row.
  task automatic test_restart();
    set_mesh(SIDES_QUAD, 2);
    repeat (3) send_word(1'b0);
    send_word(1'b1);
    send_word(1'b0);
    repeat (2) send_word(1'b1);
  endtask

  // Random settings, mostly small meshes walked to the end and past the wrap; some phases
  // restart often, and now and then the sender waits for the output to drain.
  task automatic test_random_meshes();
    int sent;
    int phase;
    int words;
    int pick;
    int sides;
    int res;
    int restart_odds;
    int hold_at;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      pick = $urandom_range(0, 9);
      if (pick <= 2) sides = SIDES_TRI;
      else if (pick <= 5) sides = SIDES_QUAD;
      else if (pick <= 7) sides = $urandom_range(5, MAX_SIDES_DEF);
      else if (pick == 8) sides = $urandom_range(0, 2);
      else sides = $urandom_range(MAX_SIDES_DEF + 1, 31);
      pick = $urandom_range(0, 9);
      if (pick <= 6) res = $urandom_range(1, 3);
      else if (pick == 7) res = $urandom_range(4, 8);
      else if (pick == 8) res = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MAX_RES_DEF, 127);
      else res = $urandom_range(9, MAX_RES_DEF);
      set_mesh(sides, res);
      words = mesh_size() * $urandom_range(1, 2) + $urandom_range(0, 3);
      if (words > 80) words = $urandom_range(40, 80);
      restart_odds = ($urandom_range(0, 4) == 0) ? 3 : 40;
      hold_at = (phase == 0 || $urandom_range(0, 4) == 0) ? words / 2 : -1;
      for (int k = 0; k < words; k++) begin
        if (k == hold_at) drain_results();
        send_word($urandom_range(1, restart_odds) == 1);
      end
      sent += words;
      phase++;
    end
  endtask

  initial begin
    int guard;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    restart_walk();
    test_reset_state();
    test_grid_modes();
    test_clamped_settings();
    test_restart();
    test_random_meshes();
    in_tvalid <= 1'b0;
    guard = 0;
    while (pending_tris.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (pending_tris.size() != 0)
      report_mismatch("triangles never emitted", 0, pending_tris.size());
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
